// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/mrc_pkg.sv -----
package mrc_pkg;

	localparam int NODE_W     = 6;
	localparam int NODE_COUNT = 1 << NODE_W;
	localparam int MESH_WIDTH_DEF = 8;

	localparam int VC_COUNT = 4;
	localparam logic [2:0] VC_CLAMP = 3'((VC_COUNT > 7) ? 7 : VC_COUNT);

	localparam logic [2:0] PORT_PX    = 3'd0;
	localparam logic [2:0] PORT_MX    = 3'd1;
	localparam logic [2:0] PORT_PY    = 3'd2;
	localparam logic [2:0] PORT_MY    = 3'd3;
	localparam logic [2:0] PORT_LOCAL = 3'd4;

	localparam logic [2:0] MODE_XY      = 3'd0;
	localparam logic [2:0] MODE_YX      = 3'd1;
	localparam logic [2:0] MODE_ROMM    = 3'd2;
	localparam logic [2:0] MODE_VALIANT = 3'd3;
	localparam logic [2:0] MODE_O1TURN  = 3'd4;
	localparam logic [2:0] MODE_WF      = 3'd5;

	localparam logic CFG_ROUTE_MODE = 1'b0;
	localparam logic CFG_OWN_NODE   = 1'b1;

	typedef struct packed {
		logic lt;
		logic gt;
	} dir_cmp_t;

endpackage

// ----- hdl/mesh_route_compute_core.sv -----
// Route computation for one router of a square 2-D mesh. Each item (destination
// node, O1TURN order bit, free VC counts at +x, +y and -y) yields one output port:
// 0 +x, 1 -x, 2 +y, 3 -y, 4 local. route_mode picks XY (codes 0, 2, 3 and the
// unused 6, 7), YX (1), O1TURN (4) or west-first adaptive (5); own_node is this
// router's row-major node number. One item is accepted every cycle while out_ready
// is high; the result passes through the input register and the result register
// around the coordinate tables and port selection. The user must write
// configuration only while no item is in flight; the block does not enforce it.
`include "assert_macros.svh"

module mesh_route_compute_core
	import mrc_pkg::*;
#(
	parameter int MESH_WIDTH = MESH_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic                cfg_index,
	input  logic [NODE_W-1:0]   cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [NODE_W-1:0]   dest_node,
	input  logic                yx_first,
	input  logic [2:0]          free_vc_plus_x,
	input  logic [2:0]          free_vc_plus_y,
	input  logic [2:0]          free_vc_minus_y,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          out_port
);

	localparam int XW     = (MESH_WIDTH > 1) ? $clog2(MESH_WIDTH) : 1;
	localparam int YMAX   = (NODE_COUNT - 1) / MESH_WIDTH;
	localparam int YW_RAW = $clog2(YMAX + 1);
	localparam int YW     = (YW_RAW < 1) ? 1 : YW_RAW;

	logic [2:0]        route_mode_q;
	logic [NODE_W-1:0] own_node_q;

	logic              v_s1;
	logic [NODE_W-1:0] dest_s1;
	logic              yx_s1;
	logic [2:0]        px_s1;
	logic [2:0]        py_s1;
	logic [2:0]        my_s1;

	logic              out_valid_q;
	logic [2:0]        out_port_q;

	logic              s1_move;
	logic [2:0]        port_next;

	logic [XW-1:0]     x_tab [NODE_COUNT];
	logic [YW-1:0]     y_tab [NODE_COUNT];

	dir_cmp_t          dx;
	dir_cmp_t          dy;
	logic [2:0]        px_c;
	logic [2:0]        py_c;
	logic [2:0]        my_c;
	logic [2:0]        port_xy;
	logic [2:0]        port_yx;
	logic [2:0]        port_wf;

	for (genvar i = 0; i < NODE_COUNT; i++) begin : g_coord
		localparam int XI = i % MESH_WIDTH;
		localparam int YI = i / MESH_WIDTH;
		assign x_tab[i] = XW'(XI);
		assign y_tab[i] = YW'(YI);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_mode_q <= MODE_XY;
			own_node_q   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_ROUTE_MODE: route_mode_q <= cfg_data[2:0];
				CFG_OWN_NODE:   own_node_q   <= cfg_data;
				default:        ;
			endcase
		end
	end

	assign s1_move  = !out_valid_q || out_ready;
	assign in_ready = !v_s1 || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (s1_move) begin
				out_valid_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dest_s1 <= dest_node;
			yx_s1   <= yx_first;
			px_s1   <= free_vc_plus_x;
			py_s1   <= free_vc_plus_y;
			my_s1   <= free_vc_minus_y;
		end
		if (s1_move && v_s1) begin
			out_port_q <= port_next;
		end
	end

	always_comb begin
		dx.lt = x_tab[dest_s1] < x_tab[own_node_q];
		dx.gt = x_tab[dest_s1] > x_tab[own_node_q];
		dy.lt = y_tab[dest_s1] < y_tab[own_node_q];
		dy.gt = y_tab[dest_s1] > y_tab[own_node_q];
		px_c  = (px_s1 > VC_CLAMP) ? VC_CLAMP : px_s1;
		py_c  = (py_s1 > VC_CLAMP) ? VC_CLAMP : py_s1;
		my_c  = (my_s1 > VC_CLAMP) ? VC_CLAMP : my_s1;
	end

	always_comb begin
		priority if (dx.lt) port_xy = PORT_MX;
		else if (dx.gt)     port_xy = PORT_PX;
		else if (dy.lt)     port_xy = PORT_MY;
		else if (dy.gt)     port_xy = PORT_PY;
		else                port_xy = PORT_LOCAL;

		priority if (dy.lt) port_yx = PORT_MY;
		else if (dy.gt)     port_yx = PORT_PY;
		else if (dx.lt)     port_yx = PORT_MX;
		else if (dx.gt)     port_yx = PORT_PX;
		else                port_yx = PORT_LOCAL;

		// east-bound: take the y port only on strictly more free VCs
		priority if (dx.gt && dy.lt) port_wf = (my_c > px_c) ? PORT_MY : PORT_PX;
		else if (dx.gt && dy.gt)     port_wf = (py_c > px_c) ? PORT_PY : PORT_PX;
		else                         port_wf = port_xy;
	end

	always_comb begin
		unique case (route_mode_q)
			MODE_YX:     port_next = port_yx;
			MODE_O1TURN: port_next = yx_s1 ? port_yx : port_xy;
			MODE_WF:     port_next = port_wf;
			default:     port_next = port_xy;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_port  = out_port_q;

	`ASSERT_IMPLIES(a_port_range, clk, arst_n, out_valid_q, out_port_q <= PORT_LOCAL)
	`ASSERT_IMPLIES(a_self_local, clk, arst_n, v_s1 && (dest_s1 == own_node_q), port_next == PORT_LOCAL)
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, v_s1 && !s1_move, v_s1 && $stable(dest_s1))

endmodule
